@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk while reset is released.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checks that a condition never holds at a rising edge of clk outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

@@ rtl/core/lmrf_pkg.sv @@
`default_nettype none

package lmrf_pkg;

    localparam int COLOR_W = 24;
    localparam int DIM_W   = 6;
    localparam int CRD_W   = 10;
    localparam int IDX_W   = 10;
    localparam int DIV_CNT_W = 4;

    typedef logic signed [CRD_W-1:0] crd_t;

    typedef enum logic [1:0] {
        CMD_FILL    = 2'd0,
        CMD_OUTLINE = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_DRAW_COLOR   = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_INIT  = 3'd0,
        ST_IDLE  = 3'd1,
        ST_CLEAR = 3'd2,
        ST_DRAW  = 3'd3,
        ST_DIV   = 3'd4,
        ST_RADDR = 3'd5,
        ST_RDATA = 3'd6,
        ST_DONE  = 3'd7
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/led_matrix_rect_framebuffer_core.sv @@
// Read: 10 divide steps turn the strip index into row and column, then the store is read.
// Fill and outline: one cycle per pixel of the rectangle clipped to the frame.
// Clear: one store entry written per cycle on the single write port.
// One item is in work at a time; a new item is taken while the previous result waits at the output.
// After reset the whole store is cleared before the first item is taken.
`default_nettype none

`include "assert_macros.svh"

module led_matrix_rect_framebuffer_core
    import lmrf_pkg::*;
#(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [COLOR_W-1:0]  cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          cmd,
    input  wire logic signed [7:0]   x_pos,
    input  wire logic signed [7:0]   y_pos,
    input  wire logic [7:0]          rect_width,
    input  wire logic [7:0]          rect_height,
    input  wire logic [IDX_W-1:0]    led_index,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [COLOR_W-1:0]       pixel_color,
    output logic                     is_read
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;

    logic [DIM_W-1:0]   frame_w_reg, frame_h_reg;
    logic [COLOR_W-1:0] draw_color_reg;

    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    crd_t               col_reg, col_next, row_reg, row_next;
    crd_t               left_reg, left_next, right_reg, right_next;
    crd_t               top_reg, top_next, bot_reg, bot_next;
    crd_t               x0c_reg, x0c_next, x1c_reg, x1c_next, y1c_reg, y1c_next;
    logic               outline_reg, outline_next;
    logic [IDX_W-1:0]   dvd_reg, dvd_next, q_reg, q_next;
    logic [DIM_W-1:0]   rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [COLOR_W-1:0] res_color_reg, res_color_next;
    logic               res_read_reg, res_read_next;
    logic               out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0] pixel_color_reg, pixel_color_next;
    logic               is_read_reg, is_read_next;

    logic [DIM_W-1:0]   eff_w, eff_h;
    crd_t               x_ext, y_ext, xr, yb, x0c, y0c, x1c, y1c, wlim, hlim;
    logic               draw_empty, accept, out_free;
    logic               clr_last, draw_last, div_last, on_border, miss;
    logic [DIM_W:0]     trial;
    logic               ge;
    logic [DIM_W-1:0]   rd_col;
    logic [ADDR_W-1:0]  draw_addr, rd_addr;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [COLOR_W-1:0] ram_wdata, ram_rdata;

    lmrf_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign eff_w = (9'(frame_w_reg) > 9'(MAX_COLS)) ? DIM_W'(MAX_COLS) : frame_w_reg;
    assign eff_h = (9'(frame_h_reg) > 9'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : frame_h_reg;

    assign x_ext = {{2{x_pos[7]}}, x_pos};
    assign y_ext = {{2{y_pos[7]}}, y_pos};
    assign xr    = x_ext + crd_t'({2'b00, rect_width}) - crd_t'(1);
    assign yb    = y_ext + crd_t'({2'b00, rect_height}) - crd_t'(1);
    assign wlim  = crd_t'({4'b0000, eff_w}) - crd_t'(1);
    assign hlim  = crd_t'({4'b0000, eff_h}) - crd_t'(1);
    assign x0c   = x_ext[CRD_W-1] ? crd_t'(0) : x_ext;
    assign y0c   = y_ext[CRD_W-1] ? crd_t'(0) : y_ext;
    assign x1c   = (xr < wlim) ? xr : wlim;
    assign y1c   = (yb < hlim) ? yb : hlim;
    assign draw_empty = (rect_width == 8'd0) || (rect_height == 8'd0)
                        || (x1c < x0c) || (y1c < y0c);

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign clr_last  = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign draw_last = (col_reg == x1c_reg) && (row_reg == y1c_reg);
    assign div_last  = (div_cnt_reg == DIV_CNT_W'(IDX_W - 1));
    assign on_border = (col_reg == left_reg) || (col_reg == right_reg)
                       || (row_reg == top_reg) || (row_reg == bot_reg);

    assign trial = {rem_reg, dvd_reg[IDX_W-1]};
    assign ge    = (trial >= {1'b0, eff_w});

    assign miss   = (eff_w == '0) || (eff_h == '0) || (q_reg >= IDX_W'(eff_h));
    assign rd_col = q_reg[0] ? (eff_w - DIM_W'(1) - rem_reg) : rem_reg;

    assign draw_addr = ADDR_W'(ADDR_W'($unsigned(row_reg)) * ADDR_W'(MAX_COLS))
                       + ADDR_W'($unsigned(col_reg));
    assign rd_addr   = ADDR_W'(ADDR_W'(q_reg) * ADDR_W'(MAX_COLS)) + ADDR_W'(rd_col);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd_t'(cmd))
                        CMD_FILL, CMD_OUTLINE:
                        begin
                            state_next = draw_empty ? ST_DONE : ST_DRAW;
                        end
                        CMD_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DIV;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DRAW:
            begin
                if (draw_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (div_last)
                begin
                    state_next = ST_RADDR;
                end
            end
            ST_RADDR:
            begin
                state_next = ST_RDATA;
            end
            ST_RDATA:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        cfg_ready = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        ram_raddr = rd_addr;
        case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_DRAW:
            begin
                ram_we    = !outline_reg || on_border;
                ram_waddr = draw_addr;
                ram_wdata = draw_color_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        clr_cnt_next     = clr_cnt_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        left_next        = left_reg;
        right_next       = right_reg;
        top_next         = top_reg;
        bot_next         = bot_reg;
        x0c_next         = x0c_reg;
        x1c_next         = x1c_reg;
        y1c_next         = y1c_reg;
        outline_next     = outline_reg;
        dvd_next         = dvd_reg;
        q_next           = q_reg;
        rem_next         = rem_reg;
        div_cnt_next     = div_cnt_reg;
        res_color_next   = res_color_reg;
        res_read_next    = res_read_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        pixel_color_next = pixel_color_reg;
        is_read_next     = is_read_reg;

        if (state_reg == ST_INIT || state_reg == ST_CLEAR)
        begin
            clr_cnt_next = clr_last ? '0 : clr_cnt_reg + ADDR_W'(1);
        end

        if (accept)
        begin
            col_next       = x0c;
            row_next       = y0c;
            left_next      = x_ext;
            right_next     = xr;
            top_next       = y_ext;
            bot_next       = yb;
            x0c_next       = x0c;
            x1c_next       = x1c;
            y1c_next       = y1c;
            outline_next   = (cmd_t'(cmd) == CMD_OUTLINE);
            dvd_next       = led_index;
            q_next         = '0;
            rem_next       = '0;
            div_cnt_next   = '0;
            res_color_next = '0;
            res_read_next  = 1'b0;
        end

        if (state_reg == ST_DRAW)
        begin
            if (col_reg == x1c_reg)
            begin
                col_next = x0c_reg;
                row_next = row_reg + crd_t'(1);
            end
            else
            begin
                col_next = col_reg + crd_t'(1);
            end
        end

        if (state_reg == ST_DIV)
        begin
            dvd_next     = dvd_reg << 1;
            q_next       = {q_reg[IDX_W-2:0], ge};
            rem_next     = ge ? DIM_W'(trial - {1'b0, eff_w}) : trial[DIM_W-1:0];
            div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
        end

        if (state_reg == ST_RDATA)
        begin
            res_color_next = miss ? '0 : ram_rdata;
            res_read_next  = 1'b1;
        end

        if (state_reg == ST_DONE && out_free)
        begin
            out_valid_next   = 1'b1;
            pixel_color_next = res_color_reg;
            is_read_next     = res_read_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            clr_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            frame_w_reg    <= DIM_W'(32);
            frame_h_reg    <= DIM_W'(32);
            draw_color_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_FRAME_WIDTH:
                    begin
                        frame_w_reg <= cfg_data[DIM_W-1:0];
                    end
                    REG_FRAME_HEIGHT:
                    begin
                        frame_h_reg <= cfg_data[DIM_W-1:0];
                    end
                    REG_DRAW_COLOR:
                    begin
                        draw_color_reg <= cfg_data;
                    end
                    default:
                    begin
                        draw_color_reg <= draw_color_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg         <= col_next;
        row_reg         <= row_next;
        left_reg        <= left_next;
        right_reg       <= right_next;
        top_reg         <= top_next;
        bot_reg         <= bot_next;
        x0c_reg         <= x0c_next;
        x1c_reg         <= x1c_next;
        y1c_reg         <= y1c_next;
        outline_reg     <= outline_next;
        dvd_reg         <= dvd_next;
        q_reg           <= q_next;
        rem_reg         <= rem_next;
        div_cnt_reg     <= div_cnt_next;
        res_color_reg   <= res_color_next;
        res_read_reg    <= res_read_next;
        pixel_color_reg <= pixel_color_next;
        is_read_reg     <= is_read_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = pixel_color_reg;
    assign is_read     = is_read_reg;

    `ASSERT_PROP(a_we_only_when_writing, clk, rst_n, ram_we |-> (state_reg == ST_INIT || state_reg == ST_CLEAR || state_reg == ST_DRAW))
    `ASSERT_PROP(a_result_from_done, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
    `ASSERT_NEVER(a_draw_in_clip, clk, rst_n, state_reg == ST_DRAW && (col_reg > x1c_reg || row_reg > y1c_reg || col_reg < x0c_reg))
    `ASSERT_PROP(a_read_rem_below_width, clk, rst_n, (state_reg == ST_RADDR && eff_w != '0) |-> (rem_reg < eff_w))

endmodule

`default_nettype wire

@@ rtl/core/lmrf_ram.sv @@
`default_nettype none

module lmrf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ tb/sv/led_matrix_rect_framebuffer_core_test.sv @@
`default_nettype none

module led_matrix_rect_framebuffer_core_test;
    import lmrf_pkg::*;

    localparam int COLS = 32;
    localparam int ROWS = 32;
    localparam int NUM_SCRIPT = 23;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_ITEMS = 180;

    typedef struct packed {
        cmd_t       op;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] w;
        logic [7:0] h;
        logic [9:0] idx;
    } draw_cmd_t;

    typedef struct packed {
        draw_cmd_t   item;
        logic        known;
        logic [23:0] color;
    } script_row_t;

    typedef struct {
        logic [23:0] color;
        logic        rd;
    } led_result_t;

    localparam script_row_t SCRIPT [NUM_SCRIPT] = '{
        '{'{CMD_READ,    8'h00, 8'h00, 8'h00, 8'h00, 10'h000}, 1'b1, 24'h000000},
        '{'{CMD_READ,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 10'h3FF}, 1'b1, 24'h000000},
        '{'{CMD_FILL,    8'h00, 8'h00, 8'h01, 8'h01, 10'h3FF}, 1'b1, 24'h000000},
        '{'{CMD_READ,    8'h00, 8'h00, 8'h00, 8'h00, 10'h000}, 1'b1, 24'hFFFFFF},
        '{'{CMD_READ,    8'h00, 8'h00, 8'h00, 8'h00, 10'h001}, 1'b1, 24'h000000},
        '{'{CMD_FILL,    8'h80, 8'h80, 8'hFF, 8'hFF, 10'h155}, 1'b1, 24'h000000},
        '{'{CMD_READ,    8'h00, 8'h00, 8'h00, 8'h00, 10'h3FF}, 1'b0, 24'h000000},
        '{'{CMD_CLEAR,   8'h7F, 8'h7F, 8'hFF, 8'hFF, 10'h3FF}, 1'b1, 24'h000000},
        '{'{CMD_READ,    8'h00, 8'h00, 8'h00, 8'h00, 10'h3FF}, 1'b1, 24'h000000},
        '{'{CMD_FILL,    8'h7F, 8'h7F, 8'hFF, 8'hFF, 10'h000}, 1'b1, 24'h000000},
        '{'{CMD_READ,    8'h00, 8'h00, 8'h00, 8'h00, 10'h3FF}, 1'b1, 24'h000000},
        '{'{CMD_OUTLINE, 8'h02, 8'h03, 8'h0A, 8'h06, 10'h000}, 1'b1, 24'h000000},
        '{'{CMD_READ,    8'h00, 8'h00, 8'h00, 8'h00, 10'h062}, 1'b0, 24'h000000},
        '{'{CMD_READ,    8'h00, 8'h00, 8'h00, 8'h00, 10'h0BD}, 1'b0, 24'h000000},
        '{'{CMD_OUTLINE, 8'h00, 8'h00, 8'h00, 8'h05, 10'h000}, 1'b1, 24'h000000},
        '{'{CMD_FILL,    8'h00, 8'h00, 8'h05, 8'h00, 10'h000}, 1'b1, 24'h000000},
        '{'{CMD_OUTLINE, 8'hFB, 8'hFB, 8'h14, 8'h14, 10'h000}, 1'b1, 24'h000000},
        '{'{CMD_READ,    8'h00, 8'h00, 8'h00, 8'h00, 10'h1CE}, 1'b0, 24'h000000},
        '{'{CMD_OUTLINE, 8'h1F, 8'h1F, 8'h01, 8'h01, 10'h000}, 1'b1, 24'h000000},
        '{'{CMD_READ,    8'h00, 8'h00, 8'h00, 8'h00, 10'h3E0}, 1'b0, 24'h000000},
        '{'{CMD_OUTLINE, 8'h0A, 8'h0A, 8'h02, 8'hFF, 10'h000}, 1'b1, 24'h000000},
        '{'{CMD_READ,    8'hAA, 8'h55, 8'hAA, 8'h55, 10'h3FE}, 1'b0, 24'h000000},
        '{'{CMD_READ,    8'h00, 8'h00, 8'h00, 8'h00, 10'h160}, 1'b0, 24'h000000}
    };

    localparam int PHASE_COLS [NUM_PHASES] = '{32, 1, 0, 20, 63, 7, 1, 32, 45, 33};
    localparam int PHASE_ROWS [NUM_PHASES] = '{32, 1, 20, 0, 63, 5, 32, 1, 13, 40};

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  cmd;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic [9:0]  led_index;
    logic        out_valid;
    logic        out_ready;
    logic [23:0] pixel_color;
    logic        is_read;

    logic [23:0] frame_mem [ROWS][COLS];
    logic [5:0]  width_reg;
    logic [5:0]  height_reg;
    logic [23:0] color_reg;
    led_result_t pending_q [$];
    led_result_t head;
    int          fail_count = 0;
    int          results_seen = 0;

    led_matrix_rect_framebuffer_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .led_index   (led_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_color (pixel_color),
        .is_read     (is_read)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int active_cols();
        return (int'(width_reg) > COLS) ? COLS : int'(width_reg);
    endfunction

    function automatic int active_rows();
        return (int'(height_reg) > ROWS) ? ROWS : int'(height_reg);
    endfunction

    task automatic paint_rect(input int x0, input int y0, input int w, input int h,
                              input bit border);
        int c_lo;
        int c_hi;
        int r_lo;
        int r_hi;
        c_lo = (x0 < 0) ? 0 : x0;
        r_lo = (y0 < 0) ? 0 : y0;
        c_hi = x0 + w - 1;
        r_hi = y0 + h - 1;
        if (c_hi > active_cols() - 1)
            c_hi = active_cols() - 1;
        if (r_hi > active_rows() - 1)
            r_hi = active_rows() - 1;
        for (int col = c_lo; col <= c_hi; col++)
        begin
            for (int row = r_lo; row <= r_hi; row++)
            begin
                if (!border || col == x0 || col == x0 + w - 1 || row == y0 || row == y0 + h - 1)
                    frame_mem[row][col] = color_reg;
            end
        end
    endtask

    task automatic apply_command(input draw_cmd_t c, output led_result_t r);
        int ew;
        int eh;
        int n;
        int row;
        int col;
        ew = active_cols();
        eh = active_rows();
        r.color = '0;
        r.rd = 1'b0;
        case (c.op)
            CMD_FILL:
                paint_rect(int'($signed(c.x)), int'($signed(c.y)), int'(c.w), int'(c.h), 1'b0);
            CMD_OUTLINE:
                paint_rect(int'($signed(c.x)), int'($signed(c.y)), int'(c.w), int'(c.h), 1'b1);
            CMD_CLEAR:
                foreach (frame_mem[i, j])
                    frame_mem[i][j] = '0;
            default:
            begin
                r.rd = 1'b1;
                n = int'(c.idx);
                if (ew != 0 && eh != 0 && n < ew * eh)
                begin
                    row = n / ew;
                    col = n % ew;
                    if (row % 2 != 0)
                        col = ew - 1 - col;
                    r.color = frame_mem[row][col];
                end
            end
        endcase
    endtask

    function automatic draw_cmd_t random_cmd();
        draw_cmd_t c;
        int sel;
        int ew;
        int eh;
        int v;
        ew = active_cols();
        eh = active_rows();
        c.x = 8'($urandom);
        c.y = 8'($urandom);
        c.w = 8'($urandom);
        c.h = 8'($urandom);
        c.idx = 10'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 2)
            c.op = CMD_CLEAR;
        else if (sel < 40)
            c.op = CMD_FILL;
        else if (sel < 58)
            c.op = CMD_OUTLINE;
        else
            c.op = CMD_READ;
        if ((c.op == CMD_FILL || c.op == CMD_OUTLINE) && $urandom_range(0, 9) != 0)
        begin
            v = int'($urandom_range(0, ew + 8)) - 4;
            c.x = 8'(v);
            v = int'($urandom_range(0, eh + 8)) - 4;
            c.y = 8'(v);
            c.w = 8'($urandom_range(0, ($urandom_range(0, 7) == 0) ? 40 : 9));
            c.h = 8'($urandom_range(0, ($urandom_range(0, 7) == 0) ? 40 : 9));
        end
        else if (c.op == CMD_READ && ew * eh > 0 && $urandom_range(0, 6) != 0)
        begin
            c.idx = 10'($urandom_range(0, ew * eh - 1));
        end
        return c;
    endfunction

    task automatic write_reg(input reg_idx_t which, input logic [23:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (which)
            REG_FRAME_WIDTH:  width_reg = value[5:0];
            REG_FRAME_HEIGHT: height_reg = value[5:0];
            REG_DRAW_COLOR:   color_reg = value;
            default:          ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int cols, input int rows, input logic [23:0] color);
        write_reg(REG_FRAME_WIDTH, {18'($urandom), 6'(cols)});
        write_reg(REG_FRAME_HEIGHT, {18'($urandom), 6'(rows)});
        write_reg(REG_DRAW_COLOR, color);
        write_reg(REG_UNUSED, 24'($urandom));
    endtask

    task automatic send_cmd(input draw_cmd_t c, output led_result_t r);
        @(negedge clk);
        in_valid <= 1'b1;
        cmd <= c.op;
        x_pos <= c.x;
        y_pos <= c.y;
        rect_width <= c.w;
        rect_height <= c.h;
        led_index <= c.idx;
        do @(posedge clk); while (in_ready !== 1'b1);
        apply_command(c, r);
    endtask

    task automatic pause_input(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            results_seen++;
            if (pending_q.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                fail_count++;
            end
            else
            begin
                head = pending_q.pop_front();
                if (pixel_color !== head.color)
                begin
                    $error("pixel_color mismatch: expected %h, got %h", head.color, pixel_color);
                    fail_count++;
                end
                if (is_read !== head.rd)
                begin
                    $error("is_read mismatch: expected %b, got %b", head.rd, is_read);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : rx_stall
        int  tick;
        int  mode;
        bit  long_hold_done;
        tick = 0;
        mode = 0;
        long_hold_done = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && results_seen >= 300)
            begin
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                if (tick % 97 == 0)
                    mode = $urandom_range(0, 3);
                tick++;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= tick[0];
                endcase
            end
        end
    end

    initial
    begin
        #80_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        led_result_t r;
        draw_cmd_t   c;
        int          burst;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = '0;
        x_pos = '0;
        y_pos = '0;
        rect_width = '0;
        rect_height = '0;
        led_index = '0;
        width_reg = 6'd32;
        height_reg = 6'd32;
        color_reg = '0;
        foreach (frame_mem[i, j])
            frame_mem[i][j] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        configure(32, 32, 24'hFFFFFF);
        for (int i = 0; i < NUM_SCRIPT; i++)
        begin
            send_cmd(SCRIPT[i].item, r);
            if (SCRIPT[i].known)
            begin
                r.color = SCRIPT[i].color;
                r.rd = (SCRIPT[i].item.op == CMD_READ);
            end
            pending_q.push_back(r);
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            configure(PHASE_COLS[p], PHASE_ROWS[p], 24'($urandom));
            burst = 0;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == 5 && k == PHASE_ITEMS / 2)
                    drain();
                if (burst == 0)
                begin
                    pause_input($urandom_range(0, 8));
                    burst = $urandom_range(1, 40);
                end
                c = random_cmd();
                send_cmd(c, r);
                pending_q.push_back(r);
                burst--;
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
